[hw/rtl/assert_macros.svh]
// Assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/itoa_pkg.sv]
package itoa_pkg;

    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 6;
    localparam int DIGIT_W     = 4;
    localparam int STORE_DEPTH = 32;
    localparam int QUEUE_DEPTH = 2;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYCLES  = VALUE_W / DIV_BITS;

    localparam int IN_TDATA_W  = ((VALUE_W + RADIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + LEN_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0]  CHAR_DIGIT = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h37;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_NULL  = 8'h00;
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic [RADIX_W-1:0] radix;
        logic               neg;
        logic               bad;
    } t_job;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] radix;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIVIDE,
        B_PREP,
        B_SIGN,
        B_DIGITS,
        B_TERM
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        return (d <= 4'd9) ? (CHAR_DIGIT + ext) : (CHAR_ALPHA + ext);
    endfunction

endpackage

[hw/rtl/itoa_ram.sv]
module itoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/itoa_front.sv]
module itoa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic signed [itoa_pkg::VALUE_W-1:0] i_value,
    input  logic [itoa_pkg::RADIX_W-1:0] i_radix,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output itoa_pkg::t_job              o_job
);
    import itoa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    t_job             cls;
    logic             push;
    logic             pop;

    // classify: sign, unsigned magnitude, radix check
    always_comb begin
        cls.neg   = i_value[VALUE_W-1];
        cls.mag   = cls.neg ? (VALUE_W'(0) - VALUE_W'(i_value)) : VALUE_W'(i_value);
        cls.radix = i_radix;
        cls.bad   = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    end

    assign o_s_tready  = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule

[hw/rtl/itoa_div.sv]
module itoa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itoa_pkg::t_div_req i_req,
    output itoa_pkg::t_div_rsp o_rsp
);
    import itoa_pkg::*;

    localparam int STEP_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [VALUE_W-1:0] r_work;
    logic [DIGIT_W-1:0] r_rem;
    logic [RADIX_W-1:0] r_radix;

    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] rem_v;
    logic [DIV_BITS-1:0] qbits;

    // restoring division, DIV_BITS steps per cycle; remainder stays below radix
    always_comb begin
        rem_v = r_rem;
        qbits = '0;
        trial = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem_v, r_work[VALUE_W-1-i]};
            if (trial >= (DIGIT_W+1)'(r_radix)) begin
                qbits[DIV_BITS-1-i] = 1'b1;
                rem_v = DIGIT_W'(trial - (DIGIT_W+1)'(r_radix));
            end else begin
                rem_v = trial[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_work  <= i_req.dividend;
                r_rem   <= '0;
                r_radix <= i_req.radix;
            end else if (r_busy) begin
                r_work <= {r_work[VALUE_W-DIV_BITS-1:0], qbits};
                r_rem  <= rem_v;
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;
    assign o_rsp.rem  = r_rem;

endmodule

[hw/rtl/itoa_back.sv]
module itoa_back #(
    parameter int DIGIT_LIMIT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  itoa_pkg::t_job                i_job,
    output itoa_pkg::t_div_req            o_div_req,
    input  itoa_pkg::t_div_rsp            i_div_rsp,
    output logic                          o_we,
    output logic [$clog2(DIGIT_LIMIT)-1:0] o_waddr,
    output logic [itoa_pkg::DIGIT_W-1:0]  o_wdata,
    output logic [$clog2(DIGIT_LIMIT)-1:0] o_raddr,
    input  logic [itoa_pkg::DIGIT_W-1:0]  i_rdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [itoa_pkg::CHAR_W-1:0]   o_char,
    output logic                          o_last,
    output logic [itoa_pkg::LEN_W-1:0]    o_len,
    output logic                          o_bad
);
    import itoa_pkg::*;

    localparam int AW    = $clog2(DIGIT_LIMIT);
    localparam int CNT_W = $clog2(DIGIT_LIMIT + 1);

    t_back_state        r_state, n_state;
    logic               r_neg, n_neg;
    logic               r_bad, n_bad;
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;

    logic               r_ov, n_ov;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_obad, n_obad;

    logic               out_free;
    logic               load;

    assign out_free = !r_ov || i_m_tready;

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_bad    = r_bad;
        n_radix  = r_radix;
        n_count  = r_count;
        n_idx    = r_idx;
        n_char   = r_char;
        n_last   = r_last;
        n_len    = r_len;
        n_obad   = r_obad;
        load     = 1'b0;
        o_job_ready        = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_div_rsp.quot;
        o_div_req.radix    = r_radix;
        o_we     = 1'b0;
        o_waddr  = r_count[AW-1:0];
        o_wdata  = i_div_rsp.rem;

        unique case (r_state)
            B_IDLE: begin
                o_job_ready        = 1'b1;
                o_div_req.dividend = i_job.mag;
                o_div_req.radix    = i_job.radix;
                if (i_job_valid) begin
                    n_neg   = i_job.neg;
                    n_bad   = i_job.bad;
                    n_radix = i_job.radix;
                    n_count = '0;
                    if (i_job.bad) begin
                        n_state = B_TERM;
                    end else begin
                        o_div_req.start = 1'b1;
                        n_state         = B_DIVIDE;
                    end
                end
            end
            B_DIVIDE: begin
                if (i_div_rsp.done) begin
                    // digits past the store size are the top ones; drop them
                    if (r_count < CNT_W'(DIGIT_LIMIT)) begin
                        o_we    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_div_rsp.quot == '0) begin
                        n_state = B_PREP;
                    end else begin
                        o_div_req.start = 1'b1;
                    end
                end
            end
            B_PREP: begin
                n_idx   = AW'(r_count - CNT_W'(1));
                n_state = r_neg ? B_SIGN : B_DIGITS;
            end
            B_SIGN: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_char  = CHAR_MINUS;
                    n_last  = 1'b0;
                    n_len   = '0;
                    n_obad  = 1'b0;
                    n_state = B_DIGITS;
                end
            end
            B_DIGITS: begin
                if (out_free) begin
                    load   = 1'b1;
                    n_char = digit_char(i_rdata);
                    n_last = 1'b0;
                    n_len  = '0;
                    n_obad = 1'b0;
                    if (r_idx == '0) begin
                        n_state = B_TERM;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            B_TERM: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_char  = CHAR_NULL;
                    n_last  = 1'b1;
                    n_len   = r_bad ? '0
                            : LEN_W'(r_neg) + LEN_W'(r_count) + LEN_W'(1);
                    n_obad  = r_bad;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase

        if (load) begin
            n_ov = 1'b1;
        end else if (i_m_tready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    // read one entry ahead: data for r_idx is present while in SIGN/DIGITS
    assign o_raddr = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_bad   <= n_bad;
        r_radix <= n_radix;
        r_count <= n_count;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_last  <= n_last;
        r_len   <= n_len;
        r_obad  <= n_obad;
    end

    assign o_m_tvalid = r_ov;
    assign o_char     = r_char;
    assign o_last     = r_last;
    assign o_len      = r_len;
    assign o_bad      = r_obad;

endmodule

[hw/rtl/signed_int_to_ascii_base_top.sv]
// Signed integer to ASCII text in radix 2..16.
// Slave channel: one beat carries a 32-bit two's complement value and a radix.
// Master channel: one beat per character, most significant first: '-' when
// negative, digits '0'-'9'/'A'-'F', then a null beat with tlast high and the
// total length (null included) in the length field. A radix outside 2..16
// yields a single null beat with tlast and tuser high and length zero.
// Each digit is one pass of the radix divider, 8 quotient bits at a time; the
// characters then leave at one per cycle while the receiver is ready.
// A two-entry queue sits between the input classifier and the converter, so
// up to two further items are taken while one converts.
// Reset (synchronous, active low) empties the queue and the output register;
// the digit store needs no clearing. When the receiver stalls the output
// register holds its beat and the converter waits; no beat is lost.
`include "assert_macros.svh"

module signed_int_to_ascii_base_top #(
    parameter int BUFFER_CHARS = 34
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] value, [36:32] radix, rest zero
    input  logic [itoa_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] character, [13:8] text_length, rest zero
    output logic [itoa_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tlast,
    // [0] bad_radix
    output logic                              o_m_tuser
);
    import itoa_pkg::*;

    // digits kept: room for sign and null, at most the store size
    localparam int DIGIT_LIMIT = (BUFFER_CHARS - 2 > STORE_DEPTH) ? STORE_DEPTH
                                                                 : BUFFER_CHARS - 2;
    localparam int AW = $clog2(DIGIT_LIMIT);

    logic               job_valid;
    logic               job_ready;
    t_job               job;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [DIGIT_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [DIGIT_W-1:0] rdata;
    logic [CHAR_W-1:0]  out_char;
    logic [LEN_W-1:0]   out_len;

    itoa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_value     (i_s_tdata[VALUE_W-1:0]),
        .i_radix     (i_s_tdata[VALUE_W+RADIX_W-1:VALUE_W]),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    itoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    itoa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_LIMIT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    itoa_back #(
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_char      (out_char),
        .o_last      (o_m_tlast),
        .o_len       (out_len),
        .o_bad       (o_m_tuser)
    );

    assign o_m_tdata = {{(OUT_TDATA_W-CHAR_W-LEN_W){1'b0}}, out_len, out_char};

    // a flagged radix is a lone null beat with no length
    `ASSERT_IMPLY(a_bad_is_null, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast && (o_m_tdata == '0))
    // only the terminator carries a length
    `ASSERT_IMPLY(a_len_on_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tdata[13:8] == '0)
    // a real conversion has at least one digit plus the null
    `ASSERT_IMPLY(a_len_min, i_clk, i_rst_n, o_m_tvalid && o_m_tlast && !o_m_tuser, o_m_tdata[13:8] >= 6'd2)
    // within a text, characters follow without bubbles
    `ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid)

endmodule

[sim/tb_top.sv]
module tb_top;
    import itoa_pkg::*;

    // Must match the instance parameter below. At 34 the store never drops digits.
    localparam int BUFFER_CHARS  = 34;
    localparam int DIGIT_LIMIT   = (BUFFER_CHARS - 2 > STORE_DEPTH) ? STORE_DEPTH
                                                                    : BUFFER_CHARS - 2;
    localparam int TEXT_CHARS    = 34;
    localparam int NUM_DIRECTED  = 23;
    localparam int ITEMS_PER_MIX = 50;   // random items in each idle mix
    localparam int TAIL_CYCLES   = 250;  // covers a full 32-digit binary conversion
    localparam int RUN_LIMIT     = 12_000_000;

    typedef enum logic [1:0] {
        ROW_PREDICT,    // expected text comes from the predictor
        ROW_TEXT,       // expected text typed into the row
        ROW_BAD         // invalid radix, single flagged null beat
    } t_row_kind;

    typedef struct packed {
        logic [VALUE_W-1:0]           value;
        logic [RADIX_W-1:0]           radix;
        t_row_kind                    kind;
        logic [TEXT_CHARS*CHAR_W-1:0] text;   // right-aligned, zero-padded
    } t_stim_row;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic              bad;
    } t_text_beat;

    // DUT inputs start at known values.
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tuser;

    // Predictor state: digits of the current conversion, least significant first.
    logic [DIGIT_W-1:0] digit_mem [STORE_DEPTH];

    t_text_beat pending_beats [$];
    t_stim_row  directed_rows [NUM_DIRECTED];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    int beats_checked  = 0;
    int bad_expected   = 0;
    int mismatches     = 0;

    signed_int_to_ascii_base_top #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT);
        $display("Timeout: %0d characters still outstanding", pending_beats.size());
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h (char beat %0d, t=%0t)",
                 what, want, got, beats_checked, $realtime);
        mismatches++;
    endtask

    task automatic push_beat(input logic [CHAR_W-1:0] ch, input logic last,
                             input logic [LEN_W-1:0] len, input logic bad);
        t_text_beat b;
        b.ch   = ch;
        b.last = last;
        b.len  = len;
        b.bad  = bad;
        pending_beats.push_back(b);
        if (bad) begin
            bad_expected++;
        end
    endtask

    // Expected character stream for one value/radix pair.
    task automatic predict_conversion(input logic [VALUE_W-1:0] value,
                                      input logic [RADIX_W-1:0] radix);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] rem;
        logic [DIGIT_W-1:0] d;
        logic [CHAR_W-1:0]  ch;
        int                 n_digits;
        int                 n_chars;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            push_beat(CHAR_NULL, 1'b1, '0, 1'b1);
            return;
        end
        neg = value[VALUE_W-1];
        // unsigned magnitude: the most negative value maps onto 2^31
        mag = neg ? (VALUE_W'(0) - value) : value;
        n_digits = 0;
        if (mag == '0) begin
            digit_mem[0] = '0;
            n_digits = 1;
        end else begin
            while (mag != '0) begin
                if (n_digits < DIGIT_LIMIT) begin
                    rem = mag % radix;
                    digit_mem[n_digits] = rem[DIGIT_W-1:0];
                    n_digits++;
                end
                mag = mag / radix;
            end
        end
        n_chars = 0;
        if (neg) begin
            push_beat(CHAR_MINUS, 1'b0, '0, 1'b0);
            n_chars++;
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            d  = digit_mem[i];
            ch = (d <= 4'd9) ? (CHAR_DIGIT + CHAR_W'(d)) : (CHAR_ALPHA + CHAR_W'(d));
            push_beat(ch, 1'b0, '0, 1'b0);
            n_chars++;
        end
        push_beat(CHAR_NULL, 1'b1, LEN_W'(n_chars + 1), 1'b0);
    endtask

    // Drive one input beat, wait for the handshake, then queue its expected text.
    task automatic issue_row(input t_stim_row row);
        int n_chars;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'({row.radix, row.value});
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        case (row.kind)
            ROW_BAD: begin
                push_beat(CHAR_NULL, 1'b1, '0, 1'b1);
            end
            ROW_TEXT: begin
                n_chars = 0;
                for (int i = TEXT_CHARS - 1; i >= 0; i--) begin
                    if (row.text[i*CHAR_W +: CHAR_W] != CHAR_NULL) begin
                        push_beat(row.text[i*CHAR_W +: CHAR_W], 1'b0, '0, 1'b0);
                        n_chars++;
                    end
                end
                push_beat(CHAR_NULL, 1'b1, LEN_W'(n_chars + 1), 1'b0);
            end
            default: begin
                predict_conversion(row.value, row.radix);
            end
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0: return VALUE_W'($urandom_range(300));
            1: return VALUE_W'(0) - VALUE_W'($urandom_range(300));
            2: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        case ($urandom_range(9))
            0: begin
                if ($urandom_range(1) == 0) begin
                    return RADIX_W'($urandom_range(1));
                end
                return RADIX_W'($urandom_range(31, 17));
            end
            1: return RADIX_MIN;
            2: return RADIX_MAX;
            default: return RADIX_W'($urandom_range(16, 2));
        endcase
    endfunction

    task automatic check_beat();
        t_text_beat want;
        if (pending_beats.size() == 0) begin
            report_mismatch("beat with nothing pending", '0, 32'(o_m_tdata));
            return;
        end
        want = pending_beats.pop_front();
        if (o_m_tdata[CHAR_W-1:0] !== want.ch) begin
            report_mismatch("character", 32'(want.ch), 32'(o_m_tdata[CHAR_W-1:0]));
        end
        if (o_m_tlast !== want.last) begin
            report_mismatch("last", 32'(want.last), 32'(o_m_tlast));
        end
        if (o_m_tdata[CHAR_W +: LEN_W] !== want.len) begin
            report_mismatch("text_length", 32'(want.len), 32'(o_m_tdata[CHAR_W +: LEN_W]));
        end
        if (o_m_tuser !== want.bad) begin
            report_mismatch("bad_radix", 32'(want.bad), 32'(o_m_tuser));
        end
        beats_checked++;
    endtask

    // Output side: check on each accepted beat, then pick the next tready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_beat();
        end
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        t_stim_row row;
        int        src_mix  [4];
        int        sink_mix [4];
        src_mix  = '{0, 71, 0, 38};
        sink_mix = '{0, 0, 71, 38};

        // Directed table: zero, the extremes in radices 2, 8, 10 and 16, small typed
        // values, invalid radices, then a few mixed cases left to the predictor.
        directed_rows = '{
            '{32'h0000_0000, 5'd10, ROW_TEXT, "0"},
            '{32'h0000_0000, 5'd2,  ROW_TEXT, "0"},
            '{32'h0000_0000, 5'd16, ROW_TEXT, "0"},
            '{32'h7FFF_FFFF, 5'd10, ROW_TEXT, "2147483647"},
            '{32'h8000_0000, 5'd10, ROW_TEXT, "-2147483648"},
            '{32'h8000_0000, 5'd2,  ROW_TEXT,
              {"-1", "0000000000", "0000000000", "0000000000", "0"}},
            '{32'h7FFF_FFFF, 5'd2,  ROW_TEXT,
              {"1111111111", "1111111111", "1111111111", "1"}},
            '{32'h8000_0000, 5'd16, ROW_TEXT, "-80000000"},
            '{32'h7FFF_FFFF, 5'd16, ROW_TEXT, "7FFFFFFF"},
            '{32'hFFFF_FFFF, 5'd10, ROW_TEXT, "-1"},
            '{32'hFFFF_FFFF, 5'd16, ROW_TEXT, "-1"},
            '{32'h7FFF_FFFF, 5'd8,  ROW_TEXT, "17777777777"},
            '{32'h0000_00FF, 5'd16, ROW_TEXT, "FF"},
            '{32'h0000_000A, 5'd11, ROW_TEXT, "A"},
            '{32'h0000_3039, 5'd10, ROW_TEXT, "12345"},
            '{32'h1234_5678, 5'd0,  ROW_BAD,  '0},
            '{32'h8000_0000, 5'd1,  ROW_BAD,  '0},
            '{32'hFFFF_FFFF, 5'd17, ROW_BAD,  '0},
            '{32'h7FFF_FFFF, 5'd31, ROW_BAD,  '0},
            '{32'hC521_974F, 5'd3,  ROW_PREDICT, '0},
            '{32'h00AB_CDEF, 5'd13, ROW_PREDICT, '0},
            '{32'h1234_5678, 5'd7,  ROW_PREDICT, '0},
            '{32'hFFFF_FFFB, 5'd5,  ROW_PREDICT, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with no idling on either side.
        foreach (directed_rows[i]) begin
            issue_row(directed_rows[i]);
        end

        // Random part, one block of items per idle mix.
        for (int mix = 0; mix < 4; mix++) begin
            src_idle_pct   = src_mix[mix];
            sink_stall_pct = sink_mix[mix];
            repeat (ITEMS_PER_MIX) begin
                row.value = random_value();
                row.radix = random_radix();
                row.kind  = ROW_PREDICT;
                row.text  = '0;
                issue_row(row);
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain, then give any stray beats time to show up.
        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d values (%0d from the directed table), %0d flagged radix",
                 items_sent, NUM_DIRECTED, bad_expected);
        $display("Checked %0d character beats over four idle/stall mixes, %0d mismatches",
                 beats_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
